FILE: rtl/quadratic_probe_hash_table_core_assert.svh
// Assertion macros used by the checker file of the hash table core.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef QUADRATIC_PROBE_HASH_TABLE_CORE_ASSERT_SVH
`define QUADRATIC_PROBE_HASH_TABLE_CORE_ASSERT_SVH

// Same-cycle implication.
`define QPH_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define QPH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/qph_pkg.sv
// ----------------------------------------------------------------------------
// qph_pkg
// Shared constants, codes and types of the quadratic probe hash table.
// ----------------------------------------------------------------------------
package qph_pkg;

  localparam int TableDepth = 2048;
  localparam int AddrW      = $clog2(TableDepth);
  localparam int SizeW      = AddrW + 1;
  localparam int KeyBytes   = 7;
  localparam int KeyW       = 8 * KeyBytes;
  localparam int HashW      = 32;
  localparam int ByteCntW   = $clog2(KeyBytes);
  localparam int BitCntW    = $clog2(HashW);

  localparam logic [SizeW-1:0] SizeReset = SizeW'(1031);
  localparam int StepLin = 599;
  localparam int StepSq  = 677;
  // Increment of the probe offset between steps: first value and growth.
  localparam logic [HashW-1:0] IncFirst = HashW'(StepLin + StepSq);
  localparam logic [HashW-1:0] IncGrow  = HashW'(2 * StepSq);

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_FOUND     = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_DELETED   = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  // One classified command handed from the front end to the probe engine.
  typedef struct packed {
    logic [1:0]       cmd;
    logic [KeyW-1:0]  key;
    logic [AddrW-1:0] home;
    logic [AddrW-1:0] inc0;
    logic [AddrW-1:0] grow;
  } qph_job_t;

endpackage

FILE: rtl/qph_if.sv
// ----------------------------------------------------------------------------
// qph_if
// Valid/ready channels: command request, result response, size write.
// ----------------------------------------------------------------------------
interface qph_req_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                cmd;
  logic [qph_pkg::KeyW-1:0]  key;
  modport source (output valid, cmd, key, input ready);
  modport sink   (input valid, cmd, key, output ready);
endinterface

interface qph_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                status;
  logic [qph_pkg::AddrW-1:0] slot;
  logic [qph_pkg::SizeW-1:0] probe_count;
  modport source (output valid, status, slot, probe_count, input ready);
  modport sink   (input valid, status, slot, probe_count, output ready);
endinterface

interface qph_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [qph_pkg::SizeW-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/qph_fifo.sv
// ----------------------------------------------------------------------------
// qph_fifo
// Two-entry job queue between the front end and the probe engine.
// ----------------------------------------------------------------------------
module qph_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  qph_pkg::qph_job_t push_data_i,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  output qph_pkg::qph_job_t pop_data_o,
  output logic              pop_valid_o,
  input  logic              pop_ready_i
);
  import qph_pkg::*;

  qph_job_t   entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

FILE: rtl/qph_front.sv
// ----------------------------------------------------------------------------
// qph_front
// Accept a command, hash the key a byte per cycle, reduce it modulo the
// table size with a bit-serial remainder unit and queue the job.
// ----------------------------------------------------------------------------
module qph_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic [qph_pkg::SizeW-1:0] size_i,
  input  logic                      cfg_wr_i,
  qph_req_if.sink                   req,
  output qph_pkg::qph_job_t         job_o,
  output logic                      job_valid_o,
  input  logic                      job_ready_i
);
  import qph_pkg::*;

  typedef enum logic [5:0] {
    F_IDLE = 6'b000001,
    F_HASH = 6'b000010,
    F_MODH = 6'b000100,
    F_MODA = 6'b001000,
    F_MODB = 6'b010000,
    F_PUSH = 6'b100000
  } front_state_e;

  front_state_e        state_q, state_d;
  logic [1:0]          cmd_q;
  logic [KeyW-1:0]     key_q, keysh_q;
  logic [HashW-1:0]    hash_q, div_q;
  logic [ByteCntW-1:0] byte_cnt_q;
  logic [BitCntW-1:0]  bit_cnt_q;
  logic [AddrW-1:0]    rem_q, home_q, inc0_q, grow_q;
  logic                kvalid_q;

  logic [HashW-1:0] hash_sum, hash_nx;
  logic [SizeW-1:0] rem_sh, rem_sub;
  logic [AddrW-1:0] rem_nx;
  logic             mod_last;

  assign req.ready   = en_i && (state_q == F_IDLE);
  assign job_valid_o = (state_q == F_PUSH);
  assign job_o       = '{cmd: cmd_q, key: key_q, home: home_q, inc0: inc0_q, grow: grow_q};

  // Hash round: h = 33 * (h + c), wrapping at 32 bits.
  assign hash_sum = hash_q + {{(HashW-8){1'b0}}, keysh_q[KeyW-1 -: 8]};
  assign hash_nx  = hash_sum + {hash_sum[HashW-6:0], 5'b0};

  // Restoring remainder step, one dividend bit per cycle.
  assign rem_sh   = {rem_q, div_q[HashW-1]};
  assign rem_sub  = rem_sh - size_i;
  assign rem_nx   = (rem_sh >= size_i) ? rem_sub[AddrW-1:0] : rem_sh[AddrW-1:0];
  assign mod_last = (bit_cnt_q == BitCntW'(HashW - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: if (req.valid && req.ready) state_d = F_HASH;
      F_HASH: if (byte_cnt_q == ByteCntW'(KeyBytes - 1)) state_d = F_MODH;
      F_MODH: if (mod_last) state_d = kvalid_q ? F_PUSH : F_MODA;
      F_MODA: if (mod_last) state_d = F_MODB;
      F_MODB: if (mod_last) state_d = F_PUSH;
      F_PUSH: if (job_ready_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_IDLE;
      kvalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr_i) begin
        kvalid_q <= 1'b0;
      end else if (state_q == F_MODB && mod_last) begin
        kvalid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      F_IDLE: begin
        cmd_q      <= req.cmd;
        key_q      <= req.key;
        keysh_q    <= req.key;
        hash_q     <= HashW'(1);
        byte_cnt_q <= '0;
      end
      F_HASH: begin
        hash_q     <= hash_nx;
        keysh_q    <= {keysh_q[KeyW-9:0], 8'b0};
        byte_cnt_q <= byte_cnt_q + ByteCntW'(1);
        div_q      <= hash_nx;
        rem_q      <= '0;
        bit_cnt_q  <= '0;
      end
      F_MODH, F_MODA, F_MODB: begin
        bit_cnt_q <= bit_cnt_q + BitCntW'(1);
        if (mod_last) begin
          rem_q <= '0;
          if (state_q == F_MODH) begin
            home_q <= rem_nx;
            div_q  <= IncFirst;
          end else if (state_q == F_MODA) begin
            inc0_q <= rem_nx;
            div_q  <= IncGrow;
          end else begin
            grow_q <= rem_nx;
          end
        end else begin
          rem_q <= rem_nx;
          div_q <= {div_q[HashW-2:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/qph_back.sv
// ----------------------------------------------------------------------------
// qph_back
// Probe engine: clear the slot memory after reset, walk the probe chain one
// memory read per step and register the result for the response channel.
// ----------------------------------------------------------------------------
module qph_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [qph_pkg::SizeW-1:0] size_i,
  input  qph_pkg::qph_job_t         job_i,
  input  logic                      job_valid_i,
  output logic                      job_ready_o,
  output logic                      clear_done_o,
  qph_rsp_if.source                 rsp
);
  import qph_pkg::*;

  typedef enum logic [4:0] {
    B_CLEAR = 5'b00001,
    B_IDLE  = 5'b00010,
    B_READ  = 5'b00100,
    B_EVAL  = 5'b01000,
    B_DONE  = 5'b10000
  } back_state_e;

  back_state_e      state_q, state_d;
  logic [KeyW:0]    slot_mem_q [TableDepth];
  logic [KeyW:0]    rd_q;
  logic [AddrW-1:0] clr_addr_q;
  qph_job_t         job_q;
  logic [AddrW-1:0] h_q, g_q, inc_q;
  logic [SizeW-1:0] i_q;
  logic [2:0]       res_status_q;
  logic [AddrW-1:0] res_slot_q;
  logic [SizeW-1:0] res_probe_q;
  logic             out_valid_q;
  logic [2:0]       out_status_q;
  logic [AddrW-1:0] out_slot_q;
  logic [SizeW-1:0] out_probe_q;

  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [KeyW:0]    mem_wdata;
  logic             occ, match, out_load;
  logic [SizeW-1:0] h_sum, g_sum, inc_sum, i_nx;
  logic [AddrW-1:0] h_nx, g_nx, inc_nx;

  assign job_ready_o  = (state_q == B_IDLE);
  assign clear_done_o = (state_q != B_CLEAR);
  assign out_load     = (state_q == B_DONE) && (!out_valid_q || rsp.ready);

  assign rsp.valid       = out_valid_q;
  assign rsp.status      = out_status_q;
  assign rsp.slot        = out_slot_q;
  assign rsp.probe_count = out_probe_q;

  assign occ   = rd_q[KeyW];
  assign match = (rd_q[KeyW-1:0] == job_q.key);

  // Advance the cumulative probe: all three sums stay below twice the size.
  assign h_sum   = {1'b0, h_q} + {1'b0, g_q};
  assign g_sum   = {1'b0, g_q} + {1'b0, inc_q};
  assign inc_sum = {1'b0, inc_q} + {1'b0, job_q.grow};
  assign h_nx    = (h_sum >= size_i) ? AddrW'(h_sum - size_i) : h_sum[AddrW-1:0];
  assign g_nx    = (g_sum >= size_i) ? AddrW'(g_sum - size_i) : g_sum[AddrW-1:0];
  assign inc_nx  = (inc_sum >= size_i) ? AddrW'(inc_sum - size_i) : inc_sum[AddrW-1:0];
  assign i_nx    = i_q + SizeW'(1);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = h_q;
    mem_wdata = {1'b1, job_q.key};
    if (state_q == B_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_q;
      mem_wdata = '0;
    end else if (state_q == B_EVAL && occ && match && job_q.cmd == CMD_DELETE) begin
      mem_we    = 1'b1;
      mem_wdata = {1'b0, job_q.key};
    end else if (state_q == B_EVAL && !occ && job_q.cmd == CMD_INSERT) begin
      mem_we    = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) slot_mem_q[mem_waddr] <= mem_wdata;
    if (state_q == B_READ) rd_q <= slot_mem_q[h_q];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_CLEAR: if (clr_addr_q == AddrW'(TableDepth - 1)) state_d = B_IDLE;
      B_IDLE: begin
        if (job_valid_i) begin
          state_d = (job_i.cmd == CMD_INSERT || job_i.cmd == CMD_SEARCH ||
                     job_i.cmd == CMD_DELETE) ? B_READ : B_DONE;
        end
      end
      B_READ: state_d = B_EVAL;
      B_EVAL: begin
        if (job_q.cmd == CMD_INSERT) begin
          state_d = (!occ || i_q == size_i) ? B_DONE : B_READ;
        end else begin
          state_d = (!occ || match || i_nx >= size_i) ? B_DONE : B_READ;
        end
      end
      B_DONE: if (out_load) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_CLEAR) clr_addr_q <= clr_addr_q + AddrW'(1);
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
      out_probe_q  <= res_probe_q;
    end
    case (state_q)
      B_IDLE: begin
        job_q        <= job_i;
        h_q          <= job_i.home;
        g_q          <= '0;
        inc_q        <= job_i.inc0;
        i_q          <= '0;
        res_status_q <= ST_NOT_FOUND;
        res_slot_q   <= '0;
        res_probe_q  <= '0;
      end
      B_EVAL: begin
        h_q   <= h_nx;
        g_q   <= g_nx;
        inc_q <= inc_nx;
        i_q   <= i_nx;
        if (job_q.cmd == CMD_INSERT) begin
          if (!occ) begin
            res_status_q <= ST_INSERTED;
            res_slot_q   <= h_q;
            res_probe_q  <= i_q;
          end else if (i_q == size_i) begin
            res_status_q <= ST_FULL;
            res_probe_q  <= size_i;
          end
        end else if (occ && match) begin
          res_status_q <= (job_q.cmd == CMD_DELETE) ? ST_DELETED : ST_FOUND;
          res_slot_q   <= h_q;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/quadratic_probe_hash_table_core.sv
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table_core
// Open-addressing hash table of 7-byte keys with quadratic probing.
// ----------------------------------------------------------------------------
// Usage:
//   req_i  : command beat (cmd: insert, search, delete; 56-bit key).
//   rsp_o  : one result beat per command (status, slot, probe_count).
//   cfg_i  : write the table size; write only while the block is idle.
// Flow: a command is hashed, reduced modulo the table size, pushed into the
//   queue and popped by the probe engine; each probe is a memory read, then
//   a compare, and the result then goes into the output register. The first
//   command after reset or after a size write also reduces the probe step
//   constants first.
// Overlap: the front end takes a new command once it has queued the last one,
//   so hashing overlaps the probe walk of earlier commands in the
//   single-read slot memory.
// Reset: the size returns to 1031 and a clearing pass writes all 2048
//   slots, one per cycle; req_i stays not ready until that pass ends.
// Stall: the result waits in the output register while the front end keeps
//   hashing the next command into the two-entry queue.
module quadratic_probe_hash_table_core (
  input  logic    clk_i,
  input  logic    rst_ni,
  qph_req_if.sink   req_i,
  qph_rsp_if.source rsp_o,
  qph_cfg_if.sink   cfg_i
);
  import qph_pkg::*;

  logic [SizeW-1:0] size_q, size_eff;
  qph_job_t         push_job, pop_job;
  logic             push_valid, push_ready, pop_valid, pop_ready;
  logic             clear_done, cfg_wr;

  // Accept size writes at any time; the user must send them only while idle, as the block does not enforce it.
  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SizeReset;
    end else if (cfg_wr) begin
      size_q <= cfg_i.data;
    end
  end

  // Clamp the size: zero acts as one, above the depth acts as the depth.
  always_comb begin
    if (size_q == '0) begin
      size_eff = SizeW'(1);
    end else if (size_q > SizeW'(TableDepth)) begin
      size_eff = SizeW'(TableDepth);
    end else begin
      size_eff = size_q;
    end
  end

  qph_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (clear_done),
    .size_i      (size_eff),
    .cfg_wr_i    (cfg_wr),
    .req         (req_i),
    .job_o       (push_job),
    .job_valid_o (push_valid),
    .job_ready_i (push_ready)
  );

  qph_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (push_job),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .pop_data_o   (pop_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready)
  );

  qph_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .size_i       (size_eff),
    .job_i        (pop_job),
    .job_valid_i  (pop_valid),
    .job_ready_o  (pop_ready),
    .clear_done_o (clear_done),
    .rsp          (rsp_o)
  );

endmodule

FILE: rtl/qph_checker.sv
// ----------------------------------------------------------------------------
// qph_checker
// Port-level checks on the result channel of the hash table core.
// ----------------------------------------------------------------------------
`include "quadratic_probe_hash_table_core_assert.svh"

module qph_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      rsp_valid_i,
  input logic                      rsp_ready_i,
  input logic [2:0]                rsp_status_i,
  input logic [qph_pkg::AddrW-1:0] rsp_slot_i,
  input logic [qph_pkg::SizeW-1:0] rsp_probe_i
);
  import qph_pkg::*;

  `QPH_ASSERT_NEXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_slot_i) && $stable(rsp_probe_i), "result changed while stalled")
  `QPH_ASSERT_IMPLY(a_status_code, rsp_valid_i, rsp_status_i <= ST_FULL, "bad status code")
  `QPH_ASSERT_IMPLY(a_slot_zero, rsp_valid_i && (rsp_status_i == ST_NOT_FOUND || rsp_status_i == ST_FULL), rsp_slot_i == '0, "slot set without a hit")
  `QPH_ASSERT_IMPLY(a_probe_zero, rsp_valid_i && rsp_status_i != ST_INSERTED && rsp_status_i != ST_FULL, rsp_probe_i == '0, "probe count set on lookup")

endmodule

bind quadratic_probe_hash_table_core qph_checker u_qph_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_slot_i   (rsp_o.slot),
  .rsp_probe_i  (rsp_o.probe_count)
);

FILE: tb/qph_scoreboard.sv
// ----------------------------------------------------------------------------
// qph_scoreboard
// Watches the command, result and size channels of the hash table core,
// keeps its own copy of the table and compares every result beat in order.
// ----------------------------------------------------------------------------
module qph_scoreboard (
  input  logic clk_i,
  input  logic rst_ni,
  qph_req_if   req,
  qph_rsp_if   rsp,
  qph_cfg_if   cfg,
  output int   fail_count_o,
  output int   outstanding_o
);
  import qph_pkg::*;

  typedef struct packed {
    logic [2:0]       status;
    logic [AddrW-1:0] slot;
    logic [SizeW-1:0] probes;
  } answer_t;

  logic [KeyW-1:0]  stored_key [TableDepth];
  bit               occupied   [TableDepth];
  logic [SizeW-1:0] size_reg;
  answer_t          awaited [$];

  initial begin
    fail_count_o  = 0;
    outstanding_o = 0;
  end

  function automatic int unsigned live_size();
    if (size_reg == 0) return 1;
    if (size_reg > TableDepth) return TableDepth;
    return 32'(size_reg);
  endfunction

  // Fold the key bytes, first byte first, with 32-bit wrap.
  function automatic int unsigned home_of(logic [KeyW-1:0] k, int unsigned n);
    bit [31:0] h;
    bit [31:0] c;
    h = 1;
    for (int b = KeyBytes - 1; b >= 0; b--) begin
      c = 32'(k[8*b +: 8]);
      h = 33 * c + 33 * h;
    end
    return h % n;
  endfunction

  function automatic int unsigned advance(int unsigned h, int unsigned i, int unsigned n);
    longint unsigned v;
    longint unsigned w;
    w = i;
    v = longint'(h) + longint'(StepLin) * w + longint'(StepSq) * w * w;
    return 32'(v % n);
  endfunction

  function automatic bit find_key(logic [KeyW-1:0] k, int unsigned n,
                                  output int unsigned where);
    int unsigned h;
    int unsigned i;
    h = home_of(k, n);
    i = 0;
    where = 0;
    while (occupied[h]) begin
      if (stored_key[h] == k) begin
        where = h;
        return 1;
      end
      h = advance(h, i, n);
      i++;
      if (i >= n) break;
    end
    return 0;
  endfunction

  // Work out the answer to one command and update the table copy.
  function automatic answer_t apply_command(logic [1:0] c, logic [KeyW-1:0] k);
    answer_t     a;
    int unsigned n;
    int unsigned h;
    int unsigned i;
    int unsigned where;
    n = live_size();
    a = '{status: ST_NOT_FOUND, slot: '0, probes: '0};
    case (c)
      CMD_INSERT: begin
        h = home_of(k, n);
        i = 0;
        while (occupied[h] && i < n) begin
          h = advance(h, i, n);
          i++;
        end
        if (occupied[h]) begin
          a.status = ST_FULL;
          a.probes = SizeW'(n);
        end else begin
          stored_key[h] = k;
          occupied[h]   = 1;
          a.status = ST_INSERTED;
          a.slot   = AddrW'(h);
          a.probes = SizeW'(i);
        end
      end
      CMD_SEARCH: begin
        if (find_key(k, n, where)) begin
          a.status = ST_FOUND;
          a.slot   = AddrW'(where);
        end
      end
      CMD_DELETE: begin
        if (find_key(k, n, where)) begin
          occupied[where] = 0;
          a.status = ST_DELETED;
          a.slot   = AddrW'(where);
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    answer_t got;
    if (!rst_ni) begin
      foreach (occupied[j]) occupied[j] = 0;
      size_reg = SizeReset;
      awaited.delete();
    end else begin
      if (cfg.valid && cfg.ready) size_reg = cfg.data;
      if (rsp.valid && rsp.ready) begin
        got = '{status: rsp.status, slot: rsp.slot, probes: rsp.probe_count};
        if (awaited.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("unexpected result beat: status %0d slot %0d probes %0d",
                     got.status, got.slot, got.probes);
        end else begin
          want = awaited.pop_front();
          if (got != want) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display({"result mismatch: expected status %0d slot %0d probes %0d,",
                        " got status %0d slot %0d probes %0d"},
                       want.status, want.slot, want.probes,
                       got.status, got.slot, got.probes);
          end
        end
      end
      if (req.valid && req.ready) awaited.push_back(apply_command(req.cmd, req.key));
    end
    outstanding_o = awaited.size();
  end

endmodule

FILE: tb/quadratic_probe_hash_table_core_tb.sv
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table_core_tb
// Drives insert, search, delete and unknown beats through the hash table core
// over a range of table sizes, with random gaps and stalls on both sides; the
// scoreboard beside the core predicts and checks every result.
// ----------------------------------------------------------------------------
module quadratic_probe_hash_table_core_tb;
  import qph_pkg::*;

  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam int CycleLimit = 2000000;
  localparam int HoldCycles = 400;

  logic clk_i;
  logic rst_ni;

  qph_req_if req ();
  qph_rsp_if rsp ();
  qph_cfg_if cfg ();

  int  fail_count;
  int  outstanding;
  int  cycles;
  int  hold_left;
  bit  calm;       // no idling on either side while set
  bit  hold_req;   // ask the receiver for one long hold-off
  bit  hold_done;

  logic [KeyW-1:0] known_keys [$];

  quadratic_probe_hash_table_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp),
    .cfg_i  (cfg)
  );

  qph_scoreboard scoreboard (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req           (req),
    .rsp           (rsp),
    .cfg           (cfg),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Give up on a hung run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off on request so the core's
  // queue fills and it stops taking commands.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp.ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= calm || ($urandom_range(99) >= 12);
    end
  end

  function automatic logic [KeyW-1:0] random_key();
    return KeyW'({$urandom, $urandom});
  endfunction

  // Prefer keys already handed to the table so searches and deletes hit.
  function automatic logic [KeyW-1:0] pick_key();
    if (known_keys.size() > 0 && $urandom_range(99) < 60)
      return known_keys[$urandom_range(known_keys.size() - 1)];
    return random_key();
  endfunction

  // Offer one command beat and hold it until the core takes it.
  task automatic send_cmd(logic [1:0] c, logic [KeyW-1:0] k);
    if (!calm && $urandom_range(99) < 12) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.cmd   <= c;
    req.key   <= k;
    if (c == CMD_INSERT) known_keys.push_back(k);
    do @(posedge clk_i); while (!req.ready);
  endtask

  // Drop valid and wait for every outstanding result.
  task automatic settle();
    req.valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  task automatic write_size(logic [SizeW-1:0] v);
    settle();
    cfg.valid <= 1'b1;
    cfg.data  <= v;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
  endtask

  task automatic run_random(int count);
    int r;
    for (int j = 0; j < count; j++) begin
      r = $urandom_range(99);
      if (r < 45)      send_cmd(CMD_INSERT, pick_key());
      else if (r < 75) send_cmd(CMD_SEARCH, pick_key());
      else if (r < 95) send_cmd(CMD_DELETE, pick_key());
      else             send_cmd(CMD_UNKNOWN, pick_key());
    end
  endtask

  initial begin
    logic [SizeW-1:0] sizes [15];
    logic [KeyW-1:0]  ka;
    logic [KeyW-1:0]  kb;
    rst_ni    = 1'b0;
    req.valid = 1'b0;
    req.cmd   = CMD_INSERT;
    req.key   = '0;
    rsp.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.data  = '0;
    cycles    = 0;
    hold_left = 0;
    hold_req  = 1'b0;
    hold_done = 1'b0;
    calm      = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: key extremes, every command, duplicates, misses.
    send_cmd(CMD_INSERT, '0);
    send_cmd(CMD_INSERT, '1);
    send_cmd(CMD_SEARCH, '0);
    send_cmd(CMD_SEARCH, '1);
    send_cmd(CMD_INSERT, '1);            // second copy of the same key
    send_cmd(CMD_SEARCH, KeyW'(56'h0123_4567_89AB_CD));
    send_cmd(CMD_DELETE, '1);
    send_cmd(CMD_SEARCH, '1);            // copy still there
    send_cmd(CMD_DELETE, KeyW'(56'hFEDC_BA98_7654_32));
    send_cmd(CMD_UNKNOWN, '1);
    send_cmd(CMD_DELETE, '0);

    // Directed: one-slot table fills on the second insert.
    write_size(SizeW'(1));
    ka = random_key();
    kb = random_key();
    send_cmd(CMD_INSERT, ka);
    send_cmd(CMD_INSERT, kb);
    send_cmd(CMD_SEARCH, kb);
    send_cmd(CMD_SEARCH, ka);
    send_cmd(CMD_DELETE, ka);

    // Random phases: extremes first, then mostly small tables that fill.
    sizes = '{SizeW'(0), SizeW'(4095), SizeW'(2048), SizeW'(1031), SizeW'(2),
              SizeW'(3), SizeW'(5), SizeW'(64), SizeW'(17), SizeW'(31),
              SizeW'($urandom_range(6, 64)), SizeW'(40), SizeW'(7), SizeW'(64),
              SizeW'($urandom_range(6, 64))};
    foreach (sizes[p]) begin
      write_size(sizes[p]);
      calm = (p == 7);
      if (p == 9) hold_req = 1'b1;
      run_random(p < 4 ? 40 : 108);
    end
    calm = 1'b0;

    settle();
    repeat (100) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
